### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, expr, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (expr)) \
    else $error(msg);

// Antecedent at one edge implies consequent at the same edge.
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/tasr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tasr_pkg
// Types, constants and helpers of the two-axis servo ramp generator.
// ---------------------------------------------------------------------------
package tasr_pkg;

  localparam logic       OP_TICK        = 1'b0;
  localparam logic       OP_MOVE        = 1'b1;
  localparam logic [7:0] ANGLE_MAX      = 8'd180;
  localparam logic [7:0] ANGLE_RESET    = 8'd90;
  localparam logic [15:0] INTERVAL_RESET = 16'd50;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  typedef struct packed {
    logic        opcode;
    logic        axis;
    logic [15:0] target_angle;
    logic [15:0] move_duration;
  } in_item_t;

  typedef struct packed {
    logic       out_axis;
    logic [7:0] angle;
    logic       last;
  } out_item_t;

  // Classified item as it sits in the queue between front and back.
  typedef struct packed {
    logic        is_move;
    logic        axis;
    logic [7:0]  goal;
    logic [15:0] dur;
  } cmd_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

### rtl/tasr_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tasr_div
// Restoring divider, one quotient bit per cycle, 8-bit quotient. The caller
// guarantees dividend < divisor * 256.
// ---------------------------------------------------------------------------
module tasr_div import tasr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [7:0]  quotient
);

  logic [15:0] rem;
  logic [15:0] dvs;
  logic [7:0]  work;
  logic [2:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic        ge;

  assign trial    = {rem, work[7]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend[23:8];
        work <= dividend[7:0];
        dvs  <= divisor;
        cnt  <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
        work <= {work[6:0], ge};
        cnt  <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/tasr_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tasr_front
// Accepts input items, clamps move targets, drops moves for absent axes and
// queues the rest in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module tasr_front import tasr_pkg::*; #(
  parameter int AXES = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  output cmd_t     q_item,
  input  logic     q_pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd;
  logic       keep;
  logic       push;
  logic       pop;

  always_comb begin
    cmd.is_move = (in_data.opcode == OP_MOVE);
    cmd.axis    = in_data.axis;
    cmd.dur     = in_data.move_duration;
    if (in_data.target_angle[15]) begin
      cmd.goal = 8'd0;
    end else if (in_data.target_angle > {8'd0, ANGLE_MAX}) begin
      cmd.goal = ANGLE_MAX;
    end else begin
      cmd.goal = in_data.target_angle[7:0];
    end
  end

  // Drop moves naming an axis that is not built.
  assign keep     = (in_data.opcode == OP_TICK) || (int'(in_data.axis) < AXES);
  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_pop && (count != 2'd0);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= cmd;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/tasr_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tasr_back
// Executes queued moves and ticks: per-axis ramp state, a scan over the axes
// on each tick, one multiply and a serial divide per intermediate point, and
// the output register.
// ---------------------------------------------------------------------------
module tasr_back import tasr_pkg::*; #(
  parameter int AXES = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] update_interval,
  input  logic        q_valid,
  input  cmd_t        q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AXES - 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIVS, S_DIV, S_EMIT} state_t;

  state_t      state;
  logic [7:0]  cur   [AXES];
  logic [7:0]  start [AXES];
  logic [7:0]  goal  [AXES];
  logic [15:0] ramp  [AXES];
  logic [15:0] tss   [AXES];
  logic [15:0] tsu   [AXES];
  logic [AXES-1:0] moving;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] sel;
  logic [23:0]      prod;
  out_item_t        pend;
  logic             pend_move;

  logic [AXES-1:0]  due_vec;
  logic             later_due;
  logic [15:0]      tss_inc;
  logic [15:0]      tsu_inc;
  logic [7:0]       diff;
  logic [7:0]       ramp_ang;
  logic             out_free;
  logic             div_done;
  logic [7:0]       div_q;

  assign sel = (state == S_IDLE) ? IDX_W'(q_item.axis) : idx;

  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      due_vec[j] = moving[j] && (sat_inc(tsu[j]) >= update_interval);
    end
    later_due = 1'b0;
    for (int j = 0; j < AXES; j++) begin
      if (j > int'(idx) && due_vec[j]) begin
        later_due = 1'b1;
      end
    end
  end

  assign tss_inc  = sat_inc(tss[sel]);
  assign tsu_inc  = sat_inc(tsu[sel]);
  assign diff     = (goal[sel] >= start[sel]) ? goal[sel] - start[sel]
                                              : start[sel] - goal[sel];
  assign ramp_ang = (goal[sel] >= start[sel]) ? start[sel] + div_q : start[sel] - div_q;
  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && q_valid;

  tasr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIVS),
    .dividend (prod),
    .divisor  (ramp[sel]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      moving    <= '0;
      out_valid <= 1'b0;
      pend_move <= 1'b0;
      for (int j = 0; j < AXES; j++) begin
        cur[j]   <= ANGLE_RESET;
        start[j] <= ANGLE_RESET;
        goal[j]  <= ANGLE_RESET;
        ramp[j]  <= 16'd0;
        tss[j]   <= 16'd0;
        tsu[j]   <= 16'd0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.is_move) begin
              goal[sel]  <= q_item.goal;
              start[sel] <= cur[sel];
              ramp[sel]  <= q_item.dur;
              tss[sel]   <= 16'd0;
              tsu[sel]   <= 16'd0;
              if (q_item.dur == 16'd0 || cur[sel] == q_item.goal) begin
                cur[sel]       <= q_item.goal;
                moving[sel]    <= 1'b0;
                pend.out_axis  <= q_item.axis;
                pend.angle     <= q_item.goal;
                pend.last      <= 1'b1;
                pend_move      <= 1'b1;
                state          <= S_EMIT;
              end else begin
                moving[sel] <= 1'b1;
              end
            end else begin
              idx   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pend.out_axis <= idx[0];
          pend.last     <= !later_due;
          pend_move     <= 1'b0;
          if (moving[sel]) begin
            tss[sel] <= tss_inc;
            tsu[sel] <= tsu_inc;
          end
          if (due_vec[sel]) begin
            if (tss_inc >= ramp[sel]) begin
              cur[sel]    <= goal[sel];
              moving[sel] <= 1'b0;
              pend.angle  <= goal[sel];
              state       <= S_EMIT;
            end else begin
              // Intermediate point: clear the update timer, divide next.
              tsu[sel] <= 16'd0;
              prod     <= {16'd0, diff} * {8'd0, tss_inc};
              state    <= S_DIVS;
            end
          end else if (idx == IDX_LAST) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DIVS: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            cur[sel]   <= ramp_ang;
            pend.angle <= ramp_ang;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= pend;
            if (pend_move || idx == IDX_LAST) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/two_axis_servo_linear_ramp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_axis_servo_linear_ramp
// Two-axis servo angle ramp generator: move commands and millisecond ticks in,
// commanded angles out.
// ---------------------------------------------------------------------------
// A move command passes the front queue and is executed when the back end
// pops it while idle; a jump then goes through the emit state. A tick scans
// the axes in order, and each axis that reaches an intermediate ramp point
// goes through the multiply register and the 8-step serial divider before
// its point is emitted; an axis that lands on its target is emitted directly.
// Results leave through an output register, and the two-entry queue buffers
// input items while the back end works or the output side stalls.
module two_axis_servo_linear_ramp import tasr_pkg::*; #(
  parameter int AXES = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

`include "assert_macros.svh"

  logic [15:0] update_interval;
  logic        q_valid;
  cmd_t        q_item;
  logic        q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      update_interval <= INTERVAL_RESET;
    end else if (cfg_we) begin
      update_interval <= cfg_wdata;
    end
  end

  tasr_front #(.AXES(AXES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  tasr_back #(.AXES(AXES)) u_back (
    .clk             (clk),
    .rst             (rst),
    .update_interval (update_interval),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

  `ASSERT_IMPLIES(a_angle_range, clk, rst, out_valid, out_data.angle <= ANGLE_MAX, "angle out of range")
  `ASSERT_IMPLIES(a_axis_range, clk, rst, out_valid, int'(out_data.out_axis) < AXES, "result for absent axis")
  `ASSERT_ALWAYS(a_full_queue, clk, rst, in_ready || q_valid, "input stalled with empty queue")

endmodule
